@@ sv/date_time_field_editor_macros.svh @@
// Assertion helpers for the date/time field editor.
`ifndef DATE_TIME_FIELD_EDITOR_MACROS_SVH
`define DATE_TIME_FIELD_EDITOR_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DTFE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while in reset.
`define DTFE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ sv/dtfe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package dtfe_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_MODE   = 3'd1,
    ACT_SELECT = 3'd2,
    ACT_UP     = 3'd3,
    ACT_DOWN   = 3'd4,
    ACT_LOAD   = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5
  } field_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_UP,
    OP_DOWN
  } fix_op_e;

  localparam logic [6:0] YEAR_MAX     = 7'd99;
  localparam logic [3:0] MONTH_MAX    = 4'd12;
  localparam logic [4:0] HOUR_MAX     = 5'd23;
  localparam logic [5:0] MINSEC_MAX   = 6'd59;
  localparam logic [9:0] PERIOD_RESET = 10'd500;

  typedef struct packed {
    logic [2:0] action;
    logic [6:0] load_year;
    logic [3:0] load_month;
    logic [4:0] load_day;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] out_year;
    logic [3:0] out_month;
    logic [4:0] out_day;
    logic [4:0] out_hour;
    logic [5:0] out_minute;
    logic [5:0] out_second;
    logic [2:0] selected_index;
    logic       in_set_mode;
    logic       blank_selected;
    logic       write_rtc;
  } out_beat_t;

  typedef struct packed {
    logic capture;  // take the input beat, apply the field change
    logic commit;   // day fix, update state and output register
  } dp_cmd_t;

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic [6:0] year);
    logic [4:0] days;
    case (month) inside
      4'd2:                   days = (year[1:0] == 2'd0) ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
      default:                days = 5'd31;
    endcase
    return days;
  endfunction

endpackage
`default_nettype wire

@@ sv/dtfe_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface dtfe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] load_year;
  logic [3:0] load_month;
  logic [4:0] load_day;
  logic [4:0] load_hour;
  logic [5:0] load_minute;
  logic [5:0] load_second;

  modport source (
    output valid, action, load_year, load_month, load_day, load_hour, load_minute,
           load_second,
    input  ready
  );
  modport sink (
    input  valid, action, load_year, load_month, load_day, load_hour, load_minute,
           load_second,
    output ready
  );
endinterface

interface dtfe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_year;
  logic [3:0] out_month;
  logic [4:0] out_day;
  logic [4:0] out_hour;
  logic [5:0] out_minute;
  logic [5:0] out_second;
  logic [2:0] selected_index;
  logic       in_set_mode;
  logic       blank_selected;
  logic       write_rtc;

  modport source (
    output valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           selected_index, in_set_mode, blank_selected, write_rtc,
    input  ready
  );
  modport sink (
    input  valid, out_year, out_month, out_day, out_hour, out_minute, out_second,
           selected_index, in_set_mode, blank_selected, write_rtc,
    output ready
  );
endinterface

interface dtfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] blink_half_period;

  modport source (output valid, blink_half_period, input ready);
  modport sink (input valid, blink_half_period, output ready);
endinterface
`default_nettype wire

@@ sv/dtfe_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtfe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dtfe_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_FIX  = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture, commit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign capture     = in_valid_i && in_ready_o;
  // result slot is free when empty or being drained this cycle
  assign commit      = (state_q == S_FIX) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = capture;
  assign cmd_o.commit  = commit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (capture) state_d = S_FIX;
      S_FIX:  if (commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/dtfe_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module dtfe_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtfe_pkg::dp_cmd_t   cmd_i,
  input  dtfe_pkg::in_beat_t  in_i,
  input  logic                cfg_we_i,
  input  logic [9:0]          cfg_period_i,
  output dtfe_pkg::out_beat_t out_o
);

  // architectural state
  logic [6:0] year_q;
  logic [3:0] month_q;
  logic [4:0] day_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q, second_q;
  logic [2:0] sel_q;
  logic       edit_q, blink_q;
  logic [9:0] tick_q, period_q;

  // candidate values between capture and commit
  logic [6:0] c_year_q, c_year_d;
  logic [3:0] c_month_q, c_month_d;
  logic [5:0] c_day_q, c_day_d;
  logic [4:0] c_hour_q, c_hour_d;
  logic [5:0] c_minute_q, c_minute_d;
  logic [5:0] c_second_q, c_second_d;
  logic [2:0] c_sel_q, c_sel_d;
  logic       c_edit_q, c_edit_d;
  logic       c_blink_q, c_blink_d;
  logic [9:0] c_tick_q, c_tick_d;
  logic       c_write_q, c_write_d;
  dtfe_pkg::fix_op_e c_op_q, c_op_d;

  dtfe_pkg::out_beat_t out_q;

  logic [9:0] tick_inc;
  logic [4:0] lim;
  logic [5:0] lim_up, rem_up, rem_dn;
  logic [4:0] fix_day;

  assign tick_inc = tick_q + 10'd1;

  // field change for one beat
  always_comb begin
    c_year_d   = year_q;
    c_month_d  = month_q;
    c_day_d    = {1'b0, day_q};
    c_hour_d   = hour_q;
    c_minute_d = minute_q;
    c_second_d = second_q;
    c_sel_d    = sel_q;
    c_edit_d   = edit_q;
    c_blink_d  = blink_q;
    c_tick_d   = tick_q;
    c_write_d  = 1'b0;
    c_op_d     = dtfe_pkg::OP_NONE;
    unique case (in_i.action)
      dtfe_pkg::ACT_TICK: begin
        c_tick_d = tick_inc;
        if (tick_inc == period_q) begin
          c_blink_d = ~blink_q;
          c_tick_d  = 10'd0;
        end
      end
      dtfe_pkg::ACT_MODE: begin
        c_write_d = edit_q;
        c_edit_d  = ~edit_q;
      end
      dtfe_pkg::ACT_LOAD: begin
        if (!edit_q) begin
          c_year_d   = (in_i.load_year > dtfe_pkg::YEAR_MAX) ? dtfe_pkg::YEAR_MAX
                                                              : in_i.load_year;
          c_month_d  = (in_i.load_month == 4'd0) ? 4'd1 :
                       (in_i.load_month > dtfe_pkg::MONTH_MAX) ? dtfe_pkg::MONTH_MAX
                                                                : in_i.load_month;
          c_day_d    = {1'b0, (in_i.load_day == 5'd0) ? 5'd1 : in_i.load_day};
          c_hour_d   = (in_i.load_hour > dtfe_pkg::HOUR_MAX) ? dtfe_pkg::HOUR_MAX
                                                              : in_i.load_hour;
          c_minute_d = (in_i.load_minute > dtfe_pkg::MINSEC_MAX) ? dtfe_pkg::MINSEC_MAX
                                                                  : in_i.load_minute;
          c_second_d = (in_i.load_second > dtfe_pkg::MINSEC_MAX) ? dtfe_pkg::MINSEC_MAX
                                                                  : in_i.load_second;
        end
      end
      dtfe_pkg::ACT_SELECT: begin
        if (edit_q) begin
          c_sel_d = (sel_q == dtfe_pkg::FLD_SECOND) ? dtfe_pkg::FLD_YEAR : sel_q + 3'd1;
        end
      end
      dtfe_pkg::ACT_UP: begin
        if (edit_q) begin
          c_op_d = dtfe_pkg::OP_UP;
          case (sel_q)
            dtfe_pkg::FLD_YEAR:
              c_year_d = (year_q == dtfe_pkg::YEAR_MAX) ? 7'd0 : year_q + 7'd1;
            dtfe_pkg::FLD_MONTH:
              c_month_d = (month_q == dtfe_pkg::MONTH_MAX) ? 4'd1 : month_q + 4'd1;
            dtfe_pkg::FLD_DAY:
              c_day_d = {1'b0, day_q} + 6'd1;
            dtfe_pkg::FLD_HOUR:
              c_hour_d = (hour_q == dtfe_pkg::HOUR_MAX) ? 5'd0 : hour_q + 5'd1;
            dtfe_pkg::FLD_MINUTE:
              c_minute_d = (minute_q == dtfe_pkg::MINSEC_MAX) ? 6'd0 : minute_q + 6'd1;
            dtfe_pkg::FLD_SECOND:
              c_second_d = (second_q == dtfe_pkg::MINSEC_MAX) ? 6'd0 : second_q + 6'd1;
            default: ;
          endcase
        end
      end
      dtfe_pkg::ACT_DOWN: begin
        if (edit_q) begin
          c_op_d = dtfe_pkg::OP_DOWN;
          case (sel_q)
            dtfe_pkg::FLD_YEAR:
              c_year_d = (year_q == 7'd0) ? dtfe_pkg::YEAR_MAX : year_q - 7'd1;
            dtfe_pkg::FLD_MONTH:
              c_month_d = (month_q == 4'd1) ? dtfe_pkg::MONTH_MAX : month_q - 4'd1;
            dtfe_pkg::FLD_DAY:
              c_day_d = {1'b0, day_q} - 6'd1;
            dtfe_pkg::FLD_HOUR:
              c_hour_d = (hour_q == 5'd0) ? dtfe_pkg::HOUR_MAX : hour_q - 5'd1;
            dtfe_pkg::FLD_MINUTE:
              c_minute_d = (minute_q == 6'd0) ? dtfe_pkg::MINSEC_MAX : minute_q - 6'd1;
            dtfe_pkg::FLD_SECOND:
              c_second_d = (second_q == 6'd0) ? dtfe_pkg::MINSEC_MAX : second_q - 6'd1;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  // day-of-month fix: day stays below twice the modulus, one subtract is enough
  assign lim    = dtfe_pkg::month_days(c_month_q, c_year_q);
  assign lim_up = {1'b0, lim} + 6'd1;
  assign rem_up = (c_day_q >= lim_up) ? c_day_q - lim_up : c_day_q;
  assign rem_dn = (c_day_q >= {1'b0, lim}) ? c_day_q - {1'b0, lim} : c_day_q;

  always_comb begin
    case (c_op_q)
      dtfe_pkg::OP_UP:   fix_day = (rem_up == 6'd0) ? 5'd1 : rem_up[4:0];
      dtfe_pkg::OP_DOWN: fix_day = (rem_dn == 6'd0) ? lim : rem_dn[4:0];
      default:           fix_day = c_day_q[4:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      c_year_q   <= c_year_d;
      c_month_q  <= c_month_d;
      c_day_q    <= c_day_d;
      c_hour_q   <= c_hour_d;
      c_minute_q <= c_minute_d;
      c_second_q <= c_second_d;
      c_sel_q    <= c_sel_d;
      c_edit_q   <= c_edit_d;
      c_blink_q  <= c_blink_d;
      c_tick_q   <= c_tick_d;
      c_write_q  <= c_write_d;
      c_op_q     <= c_op_d;
    end
    if (cmd_i.commit) begin
      out_q.out_year       <= c_year_q;
      out_q.out_month      <= c_month_q;
      out_q.out_day        <= fix_day;
      out_q.out_hour       <= c_hour_q;
      out_q.out_minute     <= c_minute_q;
      out_q.out_second     <= c_second_q;
      out_q.selected_index <= c_sel_q;
      out_q.in_set_mode    <= c_edit_q;
      out_q.blank_selected <= c_edit_q & c_blink_q;
      out_q.write_rtc      <= c_write_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q   <= 7'd0;
      month_q  <= 4'd1;
      day_q    <= 5'd1;
      hour_q   <= 5'd0;
      minute_q <= 6'd0;
      second_q <= 6'd0;
      sel_q    <= dtfe_pkg::FLD_YEAR;
      edit_q   <= 1'b0;
      blink_q  <= 1'b0;
      tick_q   <= 10'd0;
      period_q <= dtfe_pkg::PERIOD_RESET;
    end else begin
      if (cmd_i.commit) begin
        year_q   <= c_year_q;
        month_q  <= c_month_q;
        day_q    <= fix_day;
        hour_q   <= c_hour_q;
        minute_q <= c_minute_q;
        second_q <= c_second_q;
        sel_q    <= c_sel_q;
        edit_q   <= c_edit_q;
        blink_q  <= c_blink_q;
        tick_q   <= c_tick_q;
      end
      if (cfg_we_i) begin
        period_q <= cfg_period_i;
      end
    end
  end

  assign out_o = out_q;

endmodule
`default_nettype wire

@@ sv/date_time_field_editor.sv @@
// Date/time field editor: keeps year (00-99), month, day, hour, minute and second with a
// show/set mode, a selected field and a blink phase, and answers every input beat with one
// result beat carrying the fields after that beat. A capture step applies the key, tick
// or load to the fields; a commit step then folds the day back into the month length
// after an up or down key (one compare-and-subtract) and writes the state and the output
// register. A result waiting on the output does not block the next input beat; only
// when the previous result is still unread at the commit step does the block hold the
// item until the output is taken. The blink half period is written over the cfg channel,
// which is always ready; write it only while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none
module date_time_field_editor (
  input  logic       clk_i,
  input  logic       rst_ni,
  dtfe_in_if.sink    in_i,
  dtfe_out_if.source out_o,
  dtfe_cfg_if.sink   cfg_i
);

  dtfe_pkg::dp_cmd_t   cmd;
  dtfe_pkg::in_beat_t  in_beat;
  dtfe_pkg::out_beat_t out_beat;
  logic                in_ready, out_valid;

  assign in_beat.action      = in_i.action;
  assign in_beat.load_year   = in_i.load_year;
  assign in_beat.load_month  = in_i.load_month;
  assign in_beat.load_day    = in_i.load_day;
  assign in_beat.load_hour   = in_i.load_hour;
  assign in_beat.load_minute = in_i.load_minute;
  assign in_beat.load_second = in_i.load_second;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

  dtfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  dtfe_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_i         (in_beat),
    .cfg_we_i     (cfg_i.valid),
    .cfg_period_i (cfg_i.blink_half_period),
    .out_o        (out_beat)
  );

  assign out_o.out_year       = out_beat.out_year;
  assign out_o.out_month      = out_beat.out_month;
  assign out_o.out_day        = out_beat.out_day;
  assign out_o.out_hour       = out_beat.out_hour;
  assign out_o.out_minute     = out_beat.out_minute;
  assign out_o.out_second     = out_beat.out_second;
  assign out_o.selected_index = out_beat.selected_index;
  assign out_o.in_set_mode    = out_beat.in_set_mode;
  assign out_o.blank_selected = out_beat.blank_selected;
  assign out_o.write_rtc      = out_beat.write_rtc;

endmodule
`default_nettype wire

@@ sv/dtfe_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "date_time_field_editor_macros.svh"
module dtfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [3:0] out_month_i,
  input logic [4:0] out_day_i,
  input logic [2:0] selected_index_i,
  input logic       in_set_mode_i,
  input logic       blank_selected_i,
  input logic       write_rtc_i
);

  logic fields_ok;

  assign fields_ok = out_month_i >= 4'd1 && out_month_i <= 4'd12 && out_day_i >= 5'd1 &&
                     selected_index_i <= 3'd5;

  `DTFE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  // one item at a time: an accepted beat blocks the next cycle
  `DTFE_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `DTFE_ASSERT_IMP(a_write_leaves_set, clk_i, rst_ni, out_valid_i && write_rtc_i, !in_set_mode_i)
  `DTFE_ASSERT_IMP(a_blank_only_set, clk_i, rst_ni, out_valid_i && blank_selected_i, in_set_mode_i)
  `DTFE_ASSERT_IMP(a_fields_range, clk_i, rst_ni, out_valid_i, fields_ok)

endmodule

bind date_time_field_editor dtfe_checker u_dtfe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_month_i      (out_o.out_month),
  .out_day_i        (out_o.out_day),
  .selected_index_i (out_o.selected_index),
  .in_set_mode_i    (out_o.in_set_mode),
  .blank_selected_i (out_o.blank_selected),
  .write_rtc_i      (out_o.write_rtc)
);
`default_nettype wire
